/* sv/txcon_pkg.sv */
`timescale 1ns / 1ps
// shared constants, codes, tables and command/status types of the text console writer
package txcon_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 8;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // transaction field widths
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int IDX_W   = 11;
   localparam int POS_W   = 11;
   localparam int COLOR_W = 8;
   localparam int CELL_W  = COLOR_W + CHAR_W;

   // internal widths
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COLX_W = $clog2(COLUMNS + TAB_WIDTH);
   localparam int ROWX_W = $clog2(ROWS + 1);

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LINEFEED  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

   // next tab stop for every column, built at elaboration
   typedef logic [COLX_W-1:0] tab_stop_type [COLUMNS];

   function automatic tab_stop_type make_tab_stops();
      tab_stop_type stops;
      for (int i = 0; i < COLUMNS; i++) begin
         stops[i] = COLX_W'((i / TAB_WIDTH + 1) * TAB_WIDTH);
      end
      return stops;
   endfunction

   localparam tab_stop_type TAB_STOP = make_tab_stops();

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic exec;
      logic sweep_start;
      logic sweep_run;
      logic rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              scroll;
      logic              sweep_last;
   } dp_status_type;

endpackage

/* sv/txcon_req_if.sv */
`timescale 1ns / 1ps
// request channel interface: function, character and cell index
interface txcon_req_if;
   import txcon_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [CHAR_W-1:0]   char_code;
   logic [IDX_W-1:0]    cell_index;

   modport source (output valid, output func, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input func, input char_code, input cell_index,
                   output ready);
endinterface

/* sv/txcon_rsp_if.sv */
`timescale 1ns / 1ps
// response channel interface: cursor position and cell data
interface txcon_rsp_if;
   import txcon_pkg::*;

   logic                valid;
   logic                ready;
   logic [POS_W-1:0]    cursor_pos;
   logic [CELL_W-1:0]   cell_data;

   modport source (output valid, output cursor_pos, output cell_data, input ready);
   modport sink   (input valid, input cursor_pos, input cell_data, output ready);
endinterface

/* sv/text_console_char_writer_core.sv */
`timescale 1ns / 1ps
// top level of the text console character writer: controller plus datapath
//
//   channel   direction  handshake            payload
//   req_chan  in         valid / ready        func, char_code, cell_index
//   rsp_chan  out        valid / ready        cursor_pos, cell_data
//   csr       in         csr_we (no stall)    csr_wdata (text colour)
//
// put, return, tab, line feed and unused func: accept, then decode, which loads the response
// read: accept, decode, then respond; the registered read port of the cell memory adds the respond state
// scroll or clear: a sweep over the cell memory
//   at one cell per cycle through its single write port
// synchronous active-high reset clears cursor, colour (to 7) and control;
//   the cell memory holds whatever it held until written
// a finished response waits in the output register while the next request is
//   taken; decode only stalls when that register is still full
module text_console_char_writer_core (
   input  logic                          clock,
   input  logic                          reset,
   txcon_req_if.sink                     req_chan,
   txcon_rsp_if.source                   rsp_chan,
   input  logic                          csr_we,
   input  logic [txcon_pkg::COLOR_W-1:0] csr_wdata
);
   import txcon_pkg::*;

   // command and status between the two halves
   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing: idle, decode, sweep, respond
   txcon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // cursor, colour register, cell memory and response register
   txcon_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_func       (req_chan.func),
      .req_char_code  (req_chan.char_code),
      .req_cell_index (req_chan.cell_index),
      .cmd            (cmd),
      .status         (status),
      .rsp_cursor_pos (rsp_chan.cursor_pos),
      .rsp_cell_data  (rsp_chan.cell_data)
   );

endmodule

/* sv/txcon_datapath.sv */
`timescale 1ns / 1ps
// datapath: cursor, colour register, cell memory, sweep counter and response register
module txcon_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [txcon_pkg::COLOR_W-1:0] csr_wdata,
   input  logic [txcon_pkg::FUNC_W-1:0]  req_func,
   input  logic [txcon_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [txcon_pkg::IDX_W-1:0]   req_cell_index,
   input  txcon_pkg::dp_cmd_type         cmd,
   output txcon_pkg::dp_status_type      status,
   output logic [txcon_pkg::POS_W-1:0]   rsp_cursor_pos,
   output logic [txcon_pkg::CELL_W-1:0]  rsp_cell_data
);
   import txcon_pkg::*;

   // latched transaction
   logic [FUNC_W-1:0]  func_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [IDX_W-1:0]   idx_ff;

   logic [COLOR_W-1:0] color_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   // put decode
   logic [COLX_W-1:0]  col_x, col_n;
   logic [ROWX_W-1:0]  row_n;
   logic               scroll;
   logic               put_we;
   logic [COL_W-1:0]   put_col;
   logic [CHAR_W-1:0]  put_char;
   logic [ADDR_W-1:0]  put_addr;
   logic               idx_ok;

   // cell memory
   logic [CELL_W-1:0]  screen_mem [CELL_COUNT];
   logic [CELL_W-1:0]  rdata_ff;
   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [CELL_W-1:0]  blank;

   // sweep
   logic [ADDR_W-1:0]  cnt_ff;
   logic               scroll_mode_ff;
   logic               sweep_copy;
   logic               pend_ff;
   logic [ADDR_W-1:0]  pend_addr_ff;
   logic               pend_copy_ff;

   logic [POS_W-1:0]   rsp_pos_ff;
   logic [CELL_W-1:0]  rsp_data_ff;

   assign blank = {color_ff, {CHAR_W{1'b0}}};

   always_comb begin
      col_x    = COLX_W'(col_ff);
      col_n    = col_x;
      row_n    = ROWX_W'(row_ff);
      put_we   = 1'b0;
      put_col  = col_ff;
      put_char = char_ff;
      unique case (char_ff)
         CH_BACKSPACE: begin
            if (col_ff != '0) begin
               col_n    = col_x - COLX_W'(1);
               put_we   = 1'b1;
               put_col  = col_ff - COL_W'(1);
               put_char = '0;
            end
         end
         CH_TAB:      col_n = TAB_STOP[col_ff];
         CH_RETURN:   col_n = '0;
         CH_LINEFEED: begin
            col_n = '0;
            row_n = row_n + ROWX_W'(1);
         end
         default: begin
            if (char_ff >= CH_SPACE) begin
               put_we = 1'b1;
               col_n  = col_x + COLX_W'(1);
            end
         end
      endcase
      // wrap to the next row
      if (col_n >= COLX_W'(COLUMNS)) begin
         col_n = '0;
         row_n = row_n + ROWX_W'(1);
      end
      scroll   = row_n >= ROWX_W'(ROWS);
      put_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(put_col);
   end

   // cursor update
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.exec) begin
         if (func_ff == FUNC_PUT) begin
            col_in = COL_W'(col_n);
            row_in = scroll ? ROW_W'(ROWS - 1) : ROW_W'(row_n);
         end else if (func_ff == FUNC_CLEAR) begin
            col_in = '0;
            row_in = '0;
         end
      end
   end

   assign idx_ok     = {1'b0, idx_ff} < (IDX_W + 1)'(CELL_COUNT);
   assign sweep_copy = scroll_mode_ff && (cnt_ff < ADDR_W'(CELL_COUNT - COLUMNS));

   // memory port selection; a pending sweep write owns the write port
   always_comb begin
      mem_re    = cmd.exec && (func_ff == FUNC_READ);
      mem_raddr = ADDR_W'(idx_ff);
      if (cmd.sweep_run && sweep_copy) begin
         mem_re    = 1'b1;
         mem_raddr = cnt_ff + ADDR_W'(COLUMNS);
      end
      mem_we    = put_we && cmd.exec && (func_ff == FUNC_PUT);
      mem_waddr = put_addr;
      mem_wdata = {color_ff, put_char};
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = pend_copy_ff ? rdata_ff : blank;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= screen_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff       <= COLOR_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
         pend_ff        <= 1'b0;
         cnt_ff         <= '0;
         scroll_mode_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            color_ff <= csr_wdata;
         end
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= cmd.sweep_run;
         if (cmd.sweep_start) begin
            cnt_ff         <= '0;
            scroll_mode_ff <= (func_ff == FUNC_PUT);
         end else if (cmd.sweep_run) begin
            cnt_ff <= cnt_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= cnt_ff;
      pend_copy_ff <= sweep_copy;
      if (cmd.load_item) begin
         func_ff <= req_func;
         char_ff <= req_char_code;
         idx_ff  <= req_cell_index;
      end
      if (cmd.rsp_load) begin
         rsp_pos_ff  <= POS_W'(ADDR_W'(row_in) * ADDR_W'(COLUMNS) + ADDR_W'(col_in));
         rsp_data_ff <= ((func_ff == FUNC_READ) && idx_ok) ? rdata_ff : '0;
      end
   end

   assign status.func       = func_ff;
   assign status.scroll     = scroll;
   assign status.sweep_last = cnt_ff == ADDR_W'(CELL_COUNT - 1);

   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_data  = rsp_data_ff;

   // cursor never leaves the screen
   a_cursor_range : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < (COL_W + 1)'(COLUMNS)) && ({1'b0, row_ff} < (ROW_W + 1)'(ROWS)))
      else $error("cursor outside the screen");

   // a put write never meets a pending sweep write
   a_no_write_clash : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !cmd.exec)
      else $error("sweep write collides with put write");

endmodule

/* sv/txcon_ctrl.sv */
`timescale 1ns / 1ps
// controller: transaction sequencing state machine and response valid flag
module txcon_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output txcon_pkg::dp_cmd_type    cmd,
   input  txcon_pkg::dp_status_type status
);
   import txcon_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_DECODE  = 4'b0010,
      ST_SWEEP   = 4'b0100,
      ST_RESPOND = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      finish;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      finish   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.exec = 1'b1;
            if (((status.func == FUNC_PUT) && status.scroll) ||
                (status.func == FUNC_CLEAR)) begin
               cmd.sweep_start = 1'b1;
               state_in        = ST_SWEEP;
            end else if (status.func == FUNC_READ) begin
               state_in = ST_RESPOND;
            end else begin
               finish = 1'b1;
            end
         end
         ST_SWEEP: begin
            cmd.sweep_run = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: finish = 1'b1;
         default:    state_in = ST_IDLE;
      endcase
      if (finish) begin
         if (rsp_free) begin
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            state_in = ST_RESPOND;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // an accepted transaction is decoded in the next cycle
   a_accept_decode : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DECODE)
      else $error("accepted transaction not decoded");

   // the sweep ends on its last cell and hands over to the response
   a_sweep_end : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) && status.sweep_last |=> state_ff == ST_RESPOND)
      else $error("sweep overran its last cell");

endmodule
